[hdl/tce_pkg.sv]
package tce_pkg;

	// Fixed-point format
	localparam int ALPHA_FRAC_BITS = 16;
	localparam int EXTRA_FRAC_BITS = 8;

	// Port widths
	localparam int SAMPLE_W   = 16;
	localparam int TIME_W     = 64;
	localparam int CFG_W      = 32;
	localparam int REG_IDX_W  = 1;

	// Internal widths
	localparam int AVG_W      = SAMPLE_W + EXTRA_FRAC_BITS;
	localparam int DIFF_W     = AVG_W + 1;
	localparam int INT_W      = 4;                        // integer part of dt/tau, below 16
	localparam int QUO_W      = ALPHA_FRAC_BITS + INT_W;
	localparam int ALPHA_W    = ALPHA_FRAC_BITS + 1;
	localparam int REM_W      = CFG_W;
	localparam int G_W        = 33;                       // Q0.32 up to 1.0
	localparam int Y_W        = 34;                       // Q2.32, below e
	localparam int OP_W       = 33;                       // multiplier operand, signed
	localparam int MULT_W     = 2 * OP_W;
	localparam int PROD_W     = 65;
	localparam int E_SUM_W    = 35;
	localparam int E_VAL_W    = E_SUM_W - (32 - ALPHA_FRAC_BITS);
	localparam int EXP_STEPS  = 32;
	localparam int NUM_INT    = 16;
	localparam int CNT_W      = $clog2(EXP_STEPS);

	localparam logic [G_W-1:0]     ONE_Q32   = G_W'(64'h1_0000_0000);
	localparam logic [ALPHA_W-1:0] ONE_ALPHA = ALPHA_W'(1) << ALPHA_FRAC_BITS;
	localparam logic [E_SUM_W-1:0] E_ROUND   = E_SUM_W'(1) << (31 - ALPHA_FRAC_BITS);
	localparam logic [31:0]        LN2_Q32   = 32'd2977044472;

	// Register reset values
	localparam logic [CFG_W-1:0] TAU_RESET        = 32'd30000000;
	localparam logic [CFG_W-1:0] MIN_UPDATE_RESET = 32'd200000;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TAU        = 1'b0,
		REG_MIN_UPDATE = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		STAT_LOADED  = 2'd0,
		STAT_HELD    = 2'd1,
		STAT_UPDATED = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DT,
		ST_CHK,
		ST_DIV,
		ST_XINIT,
		ST_EXP,
		ST_EMUL,
		ST_ALPHA,
		ST_UMUL,
		ST_UPD,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_DIV,
		OP_EXP,
		OP_MUL
	} unit_op_t;

	typedef struct packed {
		state_t           state;
		logic [CNT_W-1:0] cnt;
	} ctl_t;

	typedef struct packed {
		logic first;
		logic too_soon;
		logic alpha_one;
		logic out_free;
	} flags_t;

	typedef struct packed {
		unit_op_t         op;
		logic [REM_W-1:0] rem;
		logic             qmsb;
		logic [CFG_W-1:0] tau;
		logic [G_W-1:0]   g;
		logic [Y_W-1:0]   y;
		logic [CNT_W-1:0] k;
		logic [OP_W-1:0]  ma;
		logic [OP_W-1:0]  mb;
	} unit_in_t;

	typedef struct packed {
		logic              ge;
		logic [G_W-1:0]    sub_res;
		logic [Y_W-1:0]    y_nxt;
		logic [MULT_W-1:0] prod;
	} unit_out_t;

	typedef logic [EXP_STEPS-1:0][31:0] ln_tab_t;
	typedef logic [NUM_INT-1:0][31:0]   exp_tab_t;

	// ln(1 + 2^-k) in Q0.32, from a Q0.60 series
	function automatic ln_tab_t build_ln_tab();
		ln_tab_t     tab;
		logic [63:0] s;
		logic [63:0] term;
		logic [63:0] rnd;
		int          k;
		int          n;
		tab = '0;
		for (k = 0; k < EXP_STEPS; k++) begin
			if (k == 0) begin
				tab[k] = LN2_Q32;
			end else begin
				s = '0;
				for (n = 1; n * k < 60; n++) begin
					term = (64'd1 << (60 - n * k)) / 64'(n);
					if ((n & 1) == 1)
						s = s + term;
					else
						s = s - term;
				end
				rnd = (s + (64'd1 << 27)) >> 28;
				tab[k] = rnd[31:0];
			end
		end
		return tab;
	endfunction

	// exp(-n) in Q0.32 for n = 1..16, entry n-1
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t    tab;
		logic [63:0] term;
		logic [63:0] s;
		logic [63:0] e1;
		logic [63:0] r;
		int          j;
		term = 64'd1 << 60;
		s = term;
		for (j = 1; j <= 20; j++) begin
			term = term / 64'(j);
			if ((j & 1) == 1)
				s = s - term;
			else
				s = s + term;
		end
		e1 = (s + (64'd1 << 27)) >> 28;
		r = e1;
		tab[0] = r[31:0];
		for (j = 1; j < NUM_INT; j++) begin
			r = (r * e1 + (64'd1 << 31)) >> 32;
			tab[j] = r[31:0];
		end
		return tab;
	endfunction

	localparam ln_tab_t  LN_TAB  = build_ln_tab();
	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

[hdl/tce_unit.sv]
// Shared arithmetic unit: one compare-subtract (divide step or log-table step),
// the y accumulate of the exponential, and one signed multiplier.
module tce_unit (
	input  tce_pkg::unit_in_t  u_in,
	output tce_pkg::unit_out_t u_out
);
	import tce_pkg::*;

	logic [G_W-1:0]   sub_a;
	logic [CFG_W-1:0] sub_b;
	logic [G_W:0]     sub_diff;
	logic             ge;

	// operand select for the shared subtractor
	always_comb begin
		unique case (u_in.op)
			OP_DIV: begin
				sub_a = {u_in.rem, u_in.qmsb};
				sub_b = u_in.tau;
			end
			OP_EXP: begin
				sub_a = u_in.g;
				sub_b = LN_TAB[u_in.k];
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end

	// compare and conditional subtract
	assign sub_diff = {1'b0, sub_a} - (G_W + 1)'(sub_b);
	assign ge       = ~sub_diff[G_W];

	always_comb begin
		u_out.ge      = ge;
		u_out.sub_res = ge ? sub_diff[G_W-1:0] : sub_a;
		u_out.y_nxt   = u_in.y + (u_in.y >> u_in.k);
		u_out.prod    = MULT_W'($signed(u_in.ma) * $signed(u_in.mb));
	end

endmodule

[hdl/tce_ctrl.sv]
// Sequencer: walks one word through delta time, throttle check and, as needed, divide,
// exponential and update, then waits for the output register.
module tce_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  tce_pkg::flags_t flags,
	output logic            in_ready,
	output tce_pkg::ctl_t   ctl
);
	import tce_pkg::*;

	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);
	localparam logic [CNT_W-1:0] EXP_LAST = CNT_W'(EXP_STEPS - 1);

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// next state and step count
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_DT;
			ST_DT:    state_d = ST_CHK;
			ST_CHK: begin
				if (flags.first || flags.too_soon)
					state_d = ST_FIN;
				else if (flags.alpha_one)
					state_d = ST_UMUL;
				else
					state_d = ST_DIV;
			end
			ST_DIV:   if (cnt_q == DIV_LAST) state_d = ST_XINIT;
			ST_XINIT: state_d = ST_EXP;
			ST_EXP:   if (cnt_q == EXP_LAST) state_d = ST_EMUL;
			ST_EMUL:  state_d = ST_ALPHA;
			ST_ALPHA: state_d = ST_UMUL;
			ST_UMUL:  state_d = ST_UPD;
			ST_UPD:   state_d = ST_FIN;
			ST_FIN:   if (flags.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
		if ((state_q == ST_DIV || state_q == ST_EXP) && state_d == state_q)
			cnt_d = cnt_q + 1'b1;
		else
			cnt_d = '0;
	end

	// outputs
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		ctl.state = state_q;
		ctl.cnt   = cnt_q;
	end

endmodule

[hdl/throttled_time_constant_ema.sv]
// Channel  Signals                                  Direction
// cfg      cfg_we, cfg_index, cfg_data              write only, no wait
// in       in_valid/in_ready, sample, now_us        one word per sample
// out      out_valid/out_ready, average, status     one word per input word
//
// A full update runs 20 divide steps and 32 exponential steps through the one
// shared subtract unit; a first or held word, or one with alpha of one, skips them.
// Reset clears the sequencer, the started flag and the average, and loads the registers with their reset values.
// A result waits in the output register while the next word is accepted;
// the last step stalls only if the output register is still full.
module throttled_time_constant_ema (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tce_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [tce_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [tce_pkg::SAMPLE_W-1:0] sample,
	input  logic [tce_pkg::TIME_W-1:0]          now_us,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [tce_pkg::SAMPLE_W-1:0] average,
	output logic [1:0]                          status
);
	import tce_pkg::*;

	ctl_t      ctl;
	flags_t    flags;
	unit_in_t  u_in;
	unit_out_t u_out;

	logic [CFG_W-1:0]           tau_q;
	logic [CFG_W-1:0]           min_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [TIME_W-1:0]          now_q;
	logic [TIME_W-1:0]          dt_q;
	logic [TIME_W-1:0]          last_q;
	logic                       started_q;
	logic signed [AVG_W-1:0]    avg_q;
	logic signed [DIFF_W-1:0]   diff_q;
	logic [REM_W-1:0]           rem_q;
	logic [QUO_W-1:0]           quo_q;
	logic [G_W-1:0]             g_q;
	logic [Y_W-1:0]             y_q;
	logic [ALPHA_W-1:0]         alpha_q;
	logic signed [PROD_W-1:0]   prod_q;
	status_t                    status_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_avg_q;
	status_t                    out_status_q;

	logic signed [AVG_W-1:0] target;
	logic [TIME_W-1:0]       tau16;
	logic                    too_soon;
	logic                    alpha_one;
	logic [G_W-1:0]          frac32;
	logic [INT_W-1:0]        int_idx;
	logic [E_SUM_W-1:0]      e_sum;
	logic [E_VAL_W-1:0]      e_val;
	logic [ALPHA_W-1:0]      alpha_calc;
	logic                    load_out;

	tce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.flags    (flags),
		.in_ready (in_ready),
		.ctl      (ctl)
	);

	tce_unit u_unit (
		.u_in  (u_in),
		.u_out (u_out)
	);

	// throttle and saturation checks on the registered interval
	assign target    = AVG_W'(sample_q) <<< EXTRA_FRAC_BITS;
	assign tau16     = TIME_W'(tau_q) << 4;
	assign too_soon  = dt_q < TIME_W'(min_q);
	assign alpha_one = dt_q >= tau16;
	assign load_out  = (ctl.state == ST_FIN) && flags.out_free;

	always_comb begin
		flags.first     = ~started_q;
		flags.too_soon  = too_soon;
		flags.alpha_one = alpha_one;
		flags.out_free  = ~out_valid_q | out_ready;
	end

	// split of dt/tau into integer and fractional parts
	assign int_idx = quo_q[ALPHA_FRAC_BITS +: INT_W];
	assign frac32  = G_W'(quo_q[ALPHA_FRAC_BITS-1:0]) << (32 - ALPHA_FRAC_BITS);

	// e = round(exp(-x)) in alpha format, clamped to one
	assign e_sum      = E_SUM_W'(prod_q[63:30]) + E_ROUND;
	assign e_val      = e_sum[E_SUM_W-1 -: E_VAL_W];
	assign alpha_calc = (e_val > E_VAL_W'(ONE_ALPHA)) ? '0 : ONE_ALPHA - e_val[ALPHA_W-1:0];

	// shared unit operands
	always_comb begin
		u_in.rem  = rem_q;
		u_in.qmsb = quo_q[QUO_W-1];
		u_in.tau  = tau_q;
		u_in.g    = g_q;
		u_in.y    = y_q;
		u_in.k    = ctl.cnt;
		u_in.op   = OP_NONE;
		u_in.ma   = '0;
		u_in.mb   = '0;
		unique case (ctl.state)
			ST_DIV: u_in.op = OP_DIV;
			ST_EXP: u_in.op = OP_EXP;
			ST_EMUL: begin
				u_in.op = OP_MUL;
				u_in.ma = OP_W'(EXP_TAB[int_idx]);
				u_in.mb = OP_W'(y_q >> 2);
			end
			ST_UMUL: begin
				u_in.op = OP_MUL;
				u_in.ma = OP_W'(alpha_q);
				u_in.mb = OP_W'(diff_q);
			end
			default: u_in.op = OP_NONE;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tau_q <= TAU_RESET;
			min_q <= MIN_UPDATE_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TAU:        tau_q <= cfg_data;
				REG_MIN_UPDATE: min_q <= cfg_data;
			endcase
		end
	end

	// filter state: started flag, average, time of last update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			avg_q     <= '0;
			last_q    <= '0;
		end else begin
			if (ctl.state == ST_CHK) begin
				if (!started_q) begin
					started_q <= 1'b1;
					avg_q     <= target;
					last_q    <= now_q;
				end else if (!too_soon) begin
					last_q <= now_q;
				end
			end else if (ctl.state == ST_UPD) begin
				avg_q <= avg_q + AVG_W'(prod_q >>> ALPHA_FRAC_BITS);
			end
		end
	end

	// working registers of the sequence
	always_ff @(posedge clk) begin
		unique case (ctl.state)
			ST_IDLE: begin
				if (in_valid) begin
					sample_q <= sample;
					now_q    <= now_us;
				end
			end
			ST_DT: dt_q <= now_q - last_q;
			ST_CHK: begin
				diff_q  <= DIFF_W'(target) - DIFF_W'(avg_q);
				rem_q   <= dt_q[REM_W+3:4];
				quo_q   <= QUO_W'(dt_q[3:0]) << ALPHA_FRAC_BITS;
				alpha_q <= ONE_ALPHA;
				if (!started_q)
					status_q <= STAT_LOADED;
				else if (too_soon)
					status_q <= STAT_HELD;
				else
					status_q <= STAT_UPDATED;
			end
			ST_DIV: begin
				rem_q <= u_out.sub_res[REM_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], u_out.ge};
			end
			ST_XINIT: begin
				g_q <= ONE_Q32 - frac32;
				y_q <= Y_W'(ONE_Q32);
			end
			ST_EXP: begin
				g_q <= u_out.sub_res;
				if (u_out.ge)
					y_q <= u_out.y_nxt;
			end
			ST_EMUL, ST_UMUL: prod_q <= u_out.prod[PROD_W-1:0];
			ST_ALPHA: alpha_q <= alpha_calc;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_avg_q    <= avg_q[AVG_W-1 -: SAMPLE_W];
			out_status_q <= status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign average   = out_avg_q;
	assign status    = out_status_q;

endmodule

[hdl/tce_checker.sv]
// Port-level checks for the moving-average block
module tce_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [tce_pkg::SAMPLE_W-1:0] average,
	input logic [1:0]                          status
);
	import tce_pkg::*;

	logic seen_q;

	// set once the first result has been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seen_q <= 1'b0;
		else if (out_valid && out_ready)
			seen_q <= 1'b1;
	end

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(average) && $stable(status))
		else $error("result word changed while stalled");

	// an accepted word keeps the block busy; no back-to-back accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while busy");

	// a new result appears only at the end of a sequence
	a_out_late: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result raised outside the final step");

	// only the first result after reset reports a load
	a_load_once: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_q |-> status != STAT_LOADED)
		else $error("load status after the first result");

	// status never shows the unused code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("unused status code");

endmodule

bind throttled_time_constant_ema tce_checker u_tce_checker (.*);

[tb/tb_throttled_time_constant_ema.sv]
module tb_throttled_time_constant_ema;
	timeunit 1ns;
	timeprecision 1ps;

	import tce_pkg::*;

	localparam int          CYCLE_LIMIT = 1_000_000;
	localparam int          TAIL_CYCLES = 80;
	localparam int          MAX_REPORTS = 10;
	localparam int          FRAC_A      = ALPHA_FRAC_BITS;
	localparam int          FRAC_E      = EXTRA_FRAC_BITS;
	localparam logic [63:0] Q32_ONE     = 64'd1 << 32;
	localparam logic [63:0] LN2_FIX     = 64'd2977044472;
	localparam logic [63:0] ALPHA_ONE   = 64'd1 << FRAC_A;
	localparam logic [31:0] TAU_AT_RST  = 32'd30000000;
	localparam logic [31:0] GAP_AT_RST  = 32'd200000;

	typedef struct {
		logic signed [SAMPLE_W-1:0] average;
		status_t                    status;
	} ema_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	logic [REG_IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]           cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic [TIME_W-1:0]          now_us;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [SAMPLE_W-1:0] average;
	logic [1:0]                 status;

	// predictor state and its copy of the registers
	logic        model_started;
	longint      model_avg;
	logic [63:0] model_last;
	logic [31:0] model_tau;
	logic [31:0] model_gap;

	ema_result_t pending[$];
	ema_result_t head_word;

	int snd_idle_pct = 19;
	int rcv_idle_pct = 63;
	int cycle_count  = 0;
	int fail_count   = 0;
	int words_sent   = 0;
	int n_checked    = 0;
	int n_writes     = 0;
	int n_loaded     = 0;
	int n_held       = 0;
	int n_updated    = 0;
	int n_alpha_one  = 0;

	throttled_time_constant_ema u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.now_us    (now_us),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.average   (average),
		.status    (status)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			pending.size());
		$display("RESULT: ERROR");
		$finish;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Q0.60 to Q0.32 with rounding
	function automatic logic [63:0] q60_round(input logic [63:0] v);
		return (v + (64'd1 << 27)) >> 28;
	endfunction

	// ln(1 + 2^-k), Q0.32
	function automatic logic [63:0] ln_step_q32(input int k);
		logic [63:0] acc;
		logic [63:0] term;
		int          n;
		if (k == 0)
			return LN2_FIX;
		acc = '0;
		for (n = 1; n * k < 60; n++) begin
			term = (64'd1 << (60 - n * k)) / 64'(n);
			if (n % 2 == 1)
				acc = acc + term;
			else
				acc = acc - term;
		end
		return q60_round(acc);
	endfunction

	// exp(-n), Q0.32: power of exp(-1), rounded at each multiply
	function automatic logic [63:0] exp_neg_q32(input int n);
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] e1;
		logic [63:0] r;
		int          j;
		term = 64'd1 << 60;
		acc = term;
		for (j = 1; j <= 20; j++) begin
			term = term / 64'(j);
			if (j % 2 == 1)
				acc = acc - term;
			else
				acc = acc + term;
		end
		e1 = q60_round(acc);
		r = e1;
		for (j = 1; j < n; j++)
			r = (r * e1 + (64'd1 << 31)) >> 32;
		return r;
	endfunction

	// alpha = 1 - exp(-dt/tau) in Q1.16
	function automatic logic [63:0] alpha_fix(input logic [63:0] dt, input logic [31:0] tau);
		logic [63:0] x;
		logic [63:0] g;
		logic [63:0] y;
		logic [63:0] step;
		logic [63:0] e32;
		logic [63:0] e;
		int          whole;
		int          k;
		if (dt >= (64'(tau) << 4))
			return ALPHA_ONE;
		x = (dt << FRAC_A) / 64'(tau);
		whole = int'(x >> FRAC_A) & 15;
		g = Q32_ONE - ((x & (ALPHA_ONE - 64'd1)) << (32 - FRAC_A));
		y = Q32_ONE;
		for (k = 0; k < 32; k++) begin
			step = ln_step_q32(k);
			if (g >= step) begin
				g = g - step;
				y = y + (y >> k);
			end
		end
		e32 = (exp_neg_q32(whole + 1) * (y >> 2)) >> 30;
		e = (e32 + (64'd1 << (31 - FRAC_A))) >> (32 - FRAC_A);
		if (e > ALPHA_ONE)
			e = ALPHA_ONE;
		return ALPHA_ONE - e;
	endfunction

	// advance the model by one accepted word, queue the result it owes
	task automatic predict_word(input logic signed [15:0] s, input logic [63:0] t);
		ema_result_t want;
		logic [63:0] dt;
		logic [63:0] a;
		longint      target;
		target = longint'(s) <<< FRAC_E;
		if (!model_started) begin
			model_started = 1'b1;
			model_avg = target;
			model_last = t;
			want.status = STAT_LOADED;
			n_loaded++;
		end else begin
			dt = t - model_last;
			if (dt < 64'(model_gap)) begin
				want.status = STAT_HELD;
				n_held++;
			end else begin
				model_last = t;
				a = alpha_fix(dt, model_tau);
				if (a == ALPHA_ONE)
					n_alpha_one++;
				// arithmetic shift is the floor of the Q16 product
				model_avg = model_avg + ((longint'(a) * (target - model_avg)) >>> FRAC_A);
				want.status = STAT_UPDATED;
				n_updated++;
			end
		end
		want.average = 16'(model_avg >>> FRAC_E);
		pending.push_back(want);
	endtask

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------

	task automatic note_failure(input string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t ns: %s", $time, what);
	endtask

	// called and returns at a falling edge; valid stays up for a back-to-back word
	task automatic send_word(input logic signed [15:0] s, input logic [63:0] t);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		now_us <= t;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		predict_word(s, t);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_after(input logic signed [15:0] s, input logic [63:0] dt);
		send_word(s, model_last + dt);
	endtask

	// hold the input side until every owed result has come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending.size() != 0);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == REG_TAU)
			model_tau = value;
		else
			model_gap = value;
		n_writes++;
	endtask

	// receiver stalls at random
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// compare each result word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending.size() == 0) begin
				note_failure($sformatf("result word with nothing pending: average %0d status %0d",
					average, status));
			end else begin
				head_word = pending.pop_front();
				n_checked++;
				if (average !== head_word.average || status !== head_word.status)
					note_failure($sformatf("average exp %0d got %0d, status exp %0d got %0d",
						head_word.average, average, head_word.status, status));
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// reset register values: load, hold, boundaries, wrap of the timestamp
	task automatic test_reset_defaults();
		send_word(16'h8000, 64'd0);
		send_after(16'h7FFF, 64'd100000);
		send_after(16'h7FFF, 64'd199999);
		send_after(16'h7FFF, 64'd200000);
		send_after(16'h0000, 64'd30000000);
		send_after(16'h00FF, 64'd479999999);
		send_after(16'h1234, 64'd480000000);
		send_word(16'hFFFF, 64'd5);
		send_word(16'h5A5A, '1);
		send_after(16'hA5A5, 64'd0);
	endtask

	// tau of zero: every update takes the sample outright
	task automatic test_zero_time_constant();
		wait_idle();
		write_reg(REG_TAU, 32'd0);
		write_reg(REG_MIN_UPDATE, 32'd0);
		send_after(16'h4000, 64'd0);
		send_after(16'hC000, 64'd1);
		send_after(16'h0001, '1);
	endtask

	// no minimum interval: dt of zero gives alpha of zero
	task automatic test_zero_interval();
		wait_idle();
		write_reg(REG_TAU, 32'd1000);
		send_after(16'h7FFF, 64'd0);
		send_after(16'h7FFF, 64'd1);
		send_after(16'h8000, 64'd15999);
		send_after(16'h8000, 64'd16000);
	endtask

	task automatic test_register_extremes();
		wait_idle();
		write_reg(REG_TAU, '1);
		write_reg(REG_MIN_UPDATE, '1);
		send_after(16'h2000, 64'hFFFF_FFFE);
		send_after(16'h2000, 64'hFFFF_FFFF);
		send_after(16'hE000, 64'hF_FFFF_FFEF);
		wait_idle();
		write_reg(REG_TAU, 32'd1);
		write_reg(REG_MIN_UPDATE, 32'd1);
		send_after(16'h1111, 64'd0);
		send_after(16'h7000, 64'd1);
		send_after(16'h9000, 64'd15);
		send_after(16'h0100, 64'd16);
	endtask

	// mostly in-order timestamps around the interesting intervals, some noise
	task automatic test_random_traffic(input int words, input logic [31:0] tau,
		input logic [31:0] min_gap);
		logic [63:0]        span;
		logic [63:0]        dt;
		logic signed [15:0] s;
		int                 pick;
		wait_idle();
		write_reg(REG_TAU, tau);
		write_reg(REG_MIN_UPDATE, min_gap);
		span = 64'(tau) << 4;
		repeat (words) begin
			pick = $urandom_range(99);
			if (pick < 12)
				dt = (min_gap == 0) ? 64'd0 : rand64() % 64'(min_gap);
			else if (pick < 50)
				dt = rand64() % (span + 64'd1);
			else if (pick < 65)
				dt = 64'(tau) * 64'($urandom_range(16)) + 64'($urandom_range(4)) - 64'd2;
			else if (pick < 72)
				dt = 64'(min_gap) - 64'($urandom_range(1));
			else if (pick < 80)
				dt = span + (rand64() >> $urandom_range(63, 20));
			else if (pick < 88)
				dt = 64'd0 - 64'($urandom_range(1000000)) - 64'd1;
			else
				dt = rand64();
			// well-formed words must clear the throttle
			if (pick >= 12 && pick < 65 && dt < 64'(min_gap))
				dt = 64'(min_gap) + dt;

			pick = $urandom_range(9);
			if (pick < 6)
				s = 16'($urandom);
			else if (pick < 8)
				s = 16'(model_avg >>> FRAC_E) + 16'($urandom_range(8)) - 16'd4;
			else
				s = $urandom_range(1) ? 16'h7FFF : 16'h8000;
			send_after(s, dt);
		end
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TAU;
		cfg_data = '0;
		in_valid = 1'b0;
		sample = '0;
		now_us = '0;
		model_started = 1'b0;
		model_avg = 0;
		model_last = '0;
		model_tau = TAU_AT_RST;
		model_gap = GAP_AT_RST;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sender light, receiver heavy stalls
		snd_idle_pct = 19;
		rcv_idle_pct = 63;
		test_reset_defaults();
		test_zero_time_constant();
		test_zero_interval();
		test_register_extremes();
		test_random_traffic(180, 32'd1000, 32'd100);
		test_random_traffic(180, $urandom, $urandom_range(5000));

		// roles swapped
		snd_idle_pct = 63;
		rcv_idle_pct = 19;
		test_random_traffic(180, 32'd1, 32'd0);
		test_random_traffic(180, TAU_AT_RST, GAP_AT_RST);

		// full rate
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_random_traffic(180, '1, '1);
		test_random_traffic(180, $urandom_range(100000, 1), $urandom_range(1000));

		wait_idle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (pending.size() != 0)
			note_failure($sformatf("%0d results never arrived", pending.size()));

		$display("Sent %0d words across %0d register writes, checked %0d results",
			words_sent, n_writes, n_checked);
		$display("  %0d loaded, %0d held, %0d updated (%0d with alpha one), %0d failures",
			n_loaded, n_held, n_updated, n_alpha_one, fail_count);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[sim.f]
hdl/tce_pkg.sv
hdl/tce_unit.sv
hdl/tce_ctrl.sv
hdl/throttled_time_constant_ema.sv
hdl/tce_checker.sv
tb/tb_throttled_time_constant_ema.sv
